### sv/bba_pkg.sv
// shared constants, payload types and status codes for the bitmap block allocator
package bba_pkg;

  localparam int MAX_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = MAX_BLOCKS / MAP_WORD_BITS;
  localparam int WORD_IDX_W    = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W     = $clog2(MAP_WORD_BITS);
  localparam int BIT_CNT_W     = BIT_IDX_W + 1;
  localparam int BLOCK_W       = 12;
  localparam int TOTAL_W       = 13;
  localparam int STATUS_W      = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(4096);
  localparam logic [TOTAL_W-1:0] LIMIT_MAX   = TOTAL_W'(MAX_BLOCKS);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_OUT         = 2'd1,
    STATUS_DOUBLE_FREE = 2'd2
  } status_t;

  typedef logic [MAP_WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic               kind;
    logic [BLOCK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] allocated_block;
    status_t            status;
  } resp_t;

endpackage

### sv/bitmap_block_allocator_unit.sv
// top level of the first-fit bitmap block allocator
//
// usage:
//   request channel: req (kind, block_number) is taken at a clock edge with
//   start high and busy low. kind allocate grants the lowest free block
//   below total_blocks (capped at the map size); kind free clears one bit.
//   result channel: done pulses for one cycle with resp (allocated_block,
//   status); the receiver cannot stall it, so it must take every transfer.
//   config: cfg_we writes total_blocks from cfg_wdata; the user must do so only while idle (not enforced).
// timing:
//   free reads its map word at accept, then writes it back in FREE_WR.
//   allocate scans the map words in SCAN until a free bit is found or the
//   last word of the range is checked (one 32-bit word per cycle through the
//   ram read port, a priority encoder on each word).
//   allocate with total_blocks of zero answers out of blocks without a scan.
//   busy is low in the cycle done is shown, so requests can run back to back.
// reset:
//   rst clears total_blocks to 4096 and runs a clearing pass in CLEAR
//   that zeroes the map one word per cycle; busy stays high until it ends.
module bitmap_block_allocator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  bba_pkg::req_t               req,
  output logic                        done,
  output bba_pkg::resp_t              resp,
  input  logic                        cfg_we,
  input  logic [bba_pkg::TOTAL_W-1:0] cfg_wdata
);
  import bba_pkg::*;

  typedef enum logic [1:0] {
    CLEAR,
    IDLE,
    SCAN,
    FREE_WR
  } state_t;

  state_t                 state;
  logic [TOTAL_W-1:0]     total_blocks;
  logic [WORD_IDX_W-1:0]  clr_idx;
  logic [WORD_IDX_W-1:0]  rd_idx;
  logic [WORD_IDX_W-1:0]  chk_idx;
  logic                   chk_valid;
  logic [WORD_IDX_W-1:0]  last_word;
  logic [BIT_CNT_W-1:0]   tail_bits;
  req_t                   req_q;

  // derived limits for a new allocate
  logic [TOTAL_W-1:0]     limit;
  logic [TOTAL_W-1:0]     limit_m1;
  logic [WORD_IDX_W-1:0]  last_word_next;
  logic [BIT_CNT_W-1:0]   tail_bits_next;

  // ram side
  logic                   ram_we;
  logic [WORD_IDX_W-1:0]  ram_waddr;
  word_t                  ram_wdata;
  logic [WORD_IDX_W-1:0]  ram_raddr;
  word_t                  ram_rdata;

  // scan of the word coming back from the ram
  logic [BIT_CNT_W-1:0]   scan_nvalid;
  logic                   scan_found;
  logic [BIT_IDX_W-1:0]   scan_bit;

  // free request fields
  logic [WORD_IDX_W-1:0]  free_word;
  logic [BIT_IDX_W-1:0]   free_bit;
  logic                   accept;

  assign accept    = start && !busy;
  assign busy      = (state != IDLE);
  assign free_word = req_q.block_number[BLOCK_W-1:BIT_IDX_W];
  assign free_bit  = req_q.block_number[BIT_IDX_W-1:0];

  // saturate the scan range to the map size
  always_comb begin
    limit          = (total_blocks > LIMIT_MAX) ? LIMIT_MAX : total_blocks;
    limit_m1       = limit - TOTAL_W'(1);
    last_word_next = WORD_IDX_W'(limit_m1 >> BIT_IDX_W);
    if (limit[BIT_IDX_W-1:0] == '0) begin
      tail_bits_next = BIT_CNT_W'(MAP_WORD_BITS);
    end else begin
      tail_bits_next = {1'b0, limit[BIT_IDX_W-1:0]};
    end
  end

  // only the last word of the range is cut short
  assign scan_nvalid = (chk_idx == last_word) ? tail_bits : BIT_CNT_W'(MAP_WORD_BITS);

  bba_word_scan u_scan (
    .word    (ram_rdata),
    .nvalid  (scan_nvalid),
    .found   (scan_found),
    .bit_idx (scan_bit)
  );

  bba_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ram read address and read-modify-write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_idx;
    ram_wdata = '0;
    ram_raddr = rd_idx;
    unique case (state)
      CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx;
        ram_wdata = '0;
      end
      IDLE: begin
        // free reads its word in the accept cycle
        ram_raddr = req.block_number[BLOCK_W-1:BIT_IDX_W];
      end
      SCAN: begin
        ram_raddr = rd_idx;
        if (chk_valid && scan_found) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx;
          ram_wdata = ram_rdata | (word_t'(1) << scan_bit);
        end
      end
      FREE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = free_word;
        ram_wdata = ram_rdata & ~(word_t'(1) << free_bit);
      end
    endcase
  end

  // sequencer, config register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CLEAR;
      clr_idx      <= '0;
      rd_idx       <= '0;
      chk_valid    <= 1'b0;
      done         <= 1'b0;
      total_blocks <= TOTAL_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        total_blocks <= cfg_wdata;
      end
      unique case (state)
        CLEAR: begin
          clr_idx <= clr_idx + WORD_IDX_W'(1);
          if (clr_idx == WORD_IDX_W'(MAP_WORDS - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (accept) begin
            req_q <= req;
            if (req.kind == KIND_FREE) begin
              state <= FREE_WR;
            end else if (limit == '0) begin
              // nothing managed: fail straight away
              done                 <= 1'b1;
              resp.allocated_block <= '0;
              resp.status          <= STATUS_OUT;
            end else begin
              state     <= SCAN;
              rd_idx    <= '0;
              chk_valid <= 1'b0;
              last_word <= last_word_next;
              tail_bits <= tail_bits_next;
            end
          end
        end
        SCAN: begin
          // read one word ahead of the word being checked
          if (rd_idx != last_word) begin
            rd_idx <= rd_idx + WORD_IDX_W'(1);
          end
          chk_idx   <= rd_idx;
          chk_valid <= 1'b1;
          if (chk_valid) begin
            if (scan_found) begin
              done                 <= 1'b1;
              resp.allocated_block <= BLOCK_W'({chk_idx, scan_bit});
              resp.status          <= STATUS_OK;
              state                <= IDLE;
              chk_valid            <= 1'b0;
            end else if (chk_idx == last_word) begin
              done                 <= 1'b1;
              resp.allocated_block <= '0;
              resp.status          <= STATUS_OUT;
              state                <= IDLE;
              chk_valid            <= 1'b0;
            end
          end
        end
        FREE_WR: begin
          done                 <= 1'b1;
          resp.allocated_block <= '0;
          resp.status          <= ram_rdata[free_bit] ? STATUS_OK : STATUS_DOUBLE_FREE;
          state                <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a result only follows a request that was taken or in progress
  a_done_has_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("result strobe without a request");

  // a failed allocate always reports block zero
  a_fail_block_zero: assert property (@(posedge clk) disable iff (rst)
    (done && resp.status == STATUS_OUT) |-> (resp.allocated_block == '0))
    else $error("out-of-blocks result with nonzero block");

  // the map is never written while the block is idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE) |-> !ram_we)
    else $error("map write while idle");

  // the check pointer trails the read pointer by one word during a scan, until the check reaches the last word
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN && chk_valid && chk_idx != last_word) |-> (rd_idx == chk_idx + WORD_IDX_W'(1)))
    else $error("scan pointers out of step");
`endif

endmodule

### sv/bba_ram.sv
// generic single-clock ram, one write port and one registered read port
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/bba_word_scan.sv
// priority encoder: lowest clear bit of one map word among its first nvalid bits
module bba_word_scan (
  input  bba_pkg::word_t                   word,
  input  logic [bba_pkg::BIT_CNT_W-1:0]    nvalid,
  output logic                             found,
  output logic [bba_pkg::BIT_IDX_W-1:0]    bit_idx
);
  import bba_pkg::*;

  always_comb begin
    found   = 1'b0;
    bit_idx = '0;
    // walk down so the lowest hit wins
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i] && (BIT_CNT_W'(i) < nvalid)) begin
        found   = 1'b1;
        bit_idx = BIT_IDX_W'(i);
      end
    end
  end

endmodule
